### design/ecb_pkg.sv
// Shared constants, tables and beat types for the camera basis pipeline.
// No dependencies; every other design file refers to it by scoped name.

package ecb_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int FIELD_W     = 16;
    localparam int TURN_UNITS  = 23040;   // 360 degrees in 1/64 degree units
    localparam int PITCH_LIMIT = 5696;    // 89 degrees
    localparam int RED_W       = 15;      // reduced angle, 0 .. TURN_UNITS-1

    // binary angle = m * 2^32 / TURN_UNITS, with TURN_UNITS = 2^DIV_SHIFT * DIV_ODD
    localparam int DIV_SHIFT   = 9;
    localparam int DIV_ODD     = TURN_UNITS >> DIV_SHIFT;
    localparam int FRAC_W      = 32 - DIV_SHIFT;
    localparam int Q_W         = DIV_SHIFT;
    localparam int REM_W       = 6;
    localparam int HALF_BIAS   = (TURN_UNITS / 2) >> DIV_SHIFT;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam int RECIP_ODD   = (1 << RECIP_SHIFT) / DIV_ODD + 1;

    localparam int CW          = 32;
    localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

    localparam int ATAN_COUNT = 32;
    localparam logic [31:0] ATAN_TURNS [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rot_t;

    typedef struct packed {
        rot_t       yaw;
        rot_t       pitch;
        logic [1:0] yaw_quad;
        logic [1:0] pitch_quad;
        logic       clamped;
    } cordic_beat_t;

endpackage

### design/ecb_if.sv
// Channel interfaces: angle pair in, basis vectors out.
// Uses ecb_pkg for the field width.

interface ecb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ecb_pkg::FIELD_W-1:0]    yaw_angle;
    logic signed [ecb_pkg::FIELD_W-1:0]    pitch_angle;

    modport source (output valid, yaw_angle, pitch_angle, input ready);
    modport sink   (input valid, yaw_angle, pitch_angle, output ready);
endinterface

interface ecb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ecb_pkg::FIELD_W-1:0]    forward_x;
    logic signed [ecb_pkg::FIELD_W-1:0]    forward_y;
    logic signed [ecb_pkg::FIELD_W-1:0]    forward_z;
    logic signed [ecb_pkg::FIELD_W-1:0]    right_x;
    logic signed [ecb_pkg::FIELD_W-1:0]    right_y;
    logic signed [ecb_pkg::FIELD_W-1:0]    right_z;
    logic signed [ecb_pkg::FIELD_W-1:0]    up_x;
    logic signed [ecb_pkg::FIELD_W-1:0]    up_y;
    logic signed [ecb_pkg::FIELD_W-1:0]    up_z;
    logic                                  pitch_was_clamped;

    modport source (output valid, forward_x, forward_y, forward_z, right_x, right_y,
                    right_z, up_x, up_y, up_z, pitch_was_clamped, input ready);
    modport sink   (input valid, forward_x, forward_y, forward_z, right_x, right_y,
                    right_z, up_x, up_y, up_z, pitch_was_clamped, output ready);
endinterface

### design/ecb_front.sv
// Angle front end: yaw wrap, pitch clamp, conversion to binary turns, quadrant split.
// Three registered stages. Depends on ecb_pkg and ecb_in_if.

module ecb_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    ecb_in_if.sink                angles,
    output logic                  valid_dn,
    input  logic                  ready_dn,
    output ecb_pkg::cordic_beat_t beat_dn
);

    localparam int RED_W  = ecb_pkg::RED_W;
    localparam int Q_W    = ecb_pkg::Q_W;
    localparam int FRAC_W = ecb_pkg::FRAC_W;
    localparam int REM_W  = ecb_pkg::REM_W;
    localparam int PROD_W = RED_W + ecb_pkg::RECIP_W;
    localparam int BIAS_W = 18;

    localparam logic [BIAS_W-1:0] WRAP1 = BIAS_W'(ecb_pkg::TURN_UNITS);
    localparam logic [BIAS_W-1:0] WRAP2 = BIAS_W'(2 * ecb_pkg::TURN_UNITS);
    localparam logic [BIAS_W-1:0] WRAP3 = BIAS_W'(3 * ecb_pkg::TURN_UNITS);
    localparam logic signed [15:0] PITCH_HI = 16'(ecb_pkg::PITCH_LIMIT);
    localparam logic signed [15:0] PITCH_LO = -PITCH_HI;

    // fractional part of the turn conversion for each remainder of m / DIV_ODD
    logic [FRAC_W-1:0] frac_tbl [ecb_pkg::DIV_ODD];

    for (genvar g = 0; g < ecb_pkg::DIV_ODD; g++)
    begin : g_frac
        localparam longint unsigned FRAC_VAL =
            ((64'(g) << FRAC_W) + ecb_pkg::HALF_BIAS) / ecb_pkg::DIV_ODD;
        assign frac_tbl[g] = FRAC_W'(FRAC_VAL);
    end

    // stage a: reduce yaw, clamp pitch
    logic             a_valid_reg;
    logic             a_ready;
    logic [RED_W-1:0] a_yaw_reg, a_yaw_next;
    logic [RED_W-1:0] a_pitch_reg, a_pitch_next;
    logic             a_clamp_reg, a_clamp_next;
    logic [BIAS_W-1:0] yaw_bias;
    logic signed [15:0] pitch_s;
    logic signed [15:0] pitch_cl;
    logic [16:0]        pitch_wrap;

    // stage b: quotient by DIV_ODD
    logic             b_valid_reg;
    logic             b_ready;
    logic [RED_W-1:0] b_yaw_m_reg, b_pitch_m_reg;
    logic [Q_W-1:0]   b_yaw_q_reg, b_yaw_q_next;
    logic [Q_W-1:0]   b_pitch_q_reg, b_pitch_q_next;
    logic             b_clamp_reg;
    logic [PROD_W-1:0] yaw_prod, pitch_prod;

    // stage c: binary angle and quadrant
    logic                  c_valid_reg;
    logic                  c_ready;
    ecb_pkg::cordic_beat_t c_beat_reg, c_beat_next;
    logic [RED_W-1:0]      yaw_rem, pitch_rem;
    logic [31:0]           yaw_turns, pitch_turns;

    function automatic ecb_pkg::rot_t start_rot(input logic [31:0] t);
        ecb_pkg::rot_t r;
        r.x = ecb_pkg::GAIN_Q30;
        r.y = '0;
        // remainder at or above 45 degrees wraps to the negative side
        r.z = ecb_pkg::CW'($signed(t[29:0]));
        return r;
    endfunction

    function automatic logic [1:0] start_quad(input logic [31:0] t);
        return t[31:30] + {1'b0, t[29]};
    endfunction

    assign a_ready = !a_valid_reg || b_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign c_ready = !c_valid_reg || ready_dn;

    assign angles.ready = a_ready;
    assign valid_dn     = c_valid_reg;
    assign beat_dn      = c_beat_reg;

    always_comb
    begin
        yaw_bias = BIAS_W'(angles.yaw_angle) + WRAP2;
        if (yaw_bias >= WRAP3)
        begin
            a_yaw_next = RED_W'(yaw_bias - WRAP3);
        end
        else if (yaw_bias >= WRAP2)
        begin
            a_yaw_next = RED_W'(yaw_bias - WRAP2);
        end
        else if (yaw_bias >= WRAP1)
        begin
            a_yaw_next = RED_W'(yaw_bias - WRAP1);
        end
        else
        begin
            a_yaw_next = RED_W'(yaw_bias);
        end

        pitch_s      = angles.pitch_angle;
        a_clamp_next = 1'b0;
        if (pitch_s > PITCH_HI)
        begin
            pitch_cl     = PITCH_HI;
            a_clamp_next = 1'b1;
        end
        else if (pitch_s < PITCH_LO)
        begin
            pitch_cl     = PITCH_LO;
            a_clamp_next = 1'b1;
        end
        else
        begin
            pitch_cl = pitch_s;
        end
        pitch_wrap   = 17'(pitch_cl) + 17'(ecb_pkg::TURN_UNITS);
        a_pitch_next = pitch_cl[15] ? pitch_wrap[RED_W-1:0] : pitch_cl[RED_W-1:0];
    end

    always_comb
    begin
        yaw_prod       = PROD_W'(a_yaw_reg) * PROD_W'(ecb_pkg::RECIP_ODD);
        pitch_prod     = PROD_W'(a_pitch_reg) * PROD_W'(ecb_pkg::RECIP_ODD);
        b_yaw_q_next   = yaw_prod[ecb_pkg::RECIP_SHIFT +: Q_W];
        b_pitch_q_next = pitch_prod[ecb_pkg::RECIP_SHIFT +: Q_W];
    end

    always_comb
    begin
        yaw_rem   = b_yaw_m_reg - RED_W'(b_yaw_q_reg) * RED_W'(ecb_pkg::DIV_ODD);
        pitch_rem = b_pitch_m_reg - RED_W'(b_pitch_q_reg) * RED_W'(ecb_pkg::DIV_ODD);
        yaw_turns   = {b_yaw_q_reg, frac_tbl[yaw_rem[REM_W-1:0]]};
        pitch_turns = {b_pitch_q_reg, frac_tbl[pitch_rem[REM_W-1:0]]};

        c_beat_next.yaw        = start_rot(yaw_turns);
        c_beat_next.pitch      = start_rot(pitch_turns);
        c_beat_next.yaw_quad   = start_quad(yaw_turns);
        c_beat_next.pitch_quad = start_quad(pitch_turns);
        c_beat_next.clamped    = b_clamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= angles.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && angles.valid)
        begin
            a_yaw_reg   <= a_yaw_next;
            a_pitch_reg <= a_pitch_next;
            a_clamp_reg <= a_clamp_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_yaw_m_reg   <= a_yaw_reg;
            b_pitch_m_reg <= a_pitch_reg;
            b_yaw_q_reg   <= b_yaw_q_next;
            b_pitch_q_reg <= b_pitch_q_next;
            b_clamp_reg   <= a_clamp_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_beat_reg <= c_beat_next;
        end
    end

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_yaw_reg < RED_W'(ecb_pkg::TURN_UNITS)) &&
                        (a_pitch_reg < RED_W'(ecb_pkg::TURN_UNITS)))
        else $error("reduced angle out of range");

    a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_clamp_reg) |->
            (a_pitch_reg == RED_W'(ecb_pkg::PITCH_LIMIT)) ||
            (a_pitch_reg == RED_W'(ecb_pkg::TURN_UNITS - ecb_pkg::PITCH_LIMIT)))
        else $error("clamped pitch not at the limit");

endmodule

### design/ecb_cordic_cell.sv
// One CORDIC rotation step for the yaw and pitch angles side by side.
// Depends on ecb_pkg; chained by the top level, one cell per stage.

module ecb_cordic_cell
#(
    parameter int STAGE = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_up,
    output logic                  ready_up,
    input  ecb_pkg::cordic_beat_t beat_up,
    output logic                  valid_dn,
    input  logic                  ready_dn,
    output ecb_pkg::cordic_beat_t beat_dn
);

    localparam logic signed [ecb_pkg::CW-1:0] ATAN =
        ecb_pkg::CW'(ecb_pkg::ATAN_TURNS[STAGE]);

    logic                  valid_reg;
    ecb_pkg::cordic_beat_t beat_reg, beat_next;

    function automatic ecb_pkg::rot_t rotate(input ecb_pkg::rot_t r);
        ecb_pkg::rot_t n;
        logic signed [ecb_pkg::CW-1:0] xs;
        logic signed [ecb_pkg::CW-1:0] ys;
        xs = r.x >>> STAGE;
        ys = r.y >>> STAGE;
        if (r.z >= 0)
        begin
            n.x = r.x - ys;
            n.y = r.y + xs;
            n.z = r.z - ATAN;
        end
        else
        begin
            n.x = r.x + ys;
            n.y = r.y - xs;
            n.z = r.z + ATAN;
        end
        return n;
    endfunction

    always_comb
    begin
        beat_next       = beat_up;
        beat_next.yaw   = rotate(beat_up.yaw);
        beat_next.pitch = rotate(beat_up.pitch);
    end

    assign ready_up = !valid_reg || ready_dn;
    assign valid_dn = valid_reg;
    assign beat_dn  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

### design/ecb_back.sv
// Back end: quadrant restore, the four cross products, rounding and the output register.
// Depends on ecb_pkg and ecb_out_if.

module ecb_back
#(
    parameter int OUT_FRAC_BITS = ecb_pkg::OUT_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_up,
    output logic                  ready_up,
    input  ecb_pkg::cordic_beat_t beat_up,
    ecb_out_if.source             basis
);

    localparam int CW      = ecb_pkg::CW;
    localparam int FW      = ecb_pkg::FIELD_W;
    localparam int SW      = CW + 2;
    localparam int PW      = 2 * CW + 2;
    localparam int SH_S    = 30 - OUT_FRAC_BITS;
    localparam int SH_P    = 60 - OUT_FRAC_BITS;

    localparam logic signed [SW-1:0] HALF_S = SW'((64'd1 << SH_S) >> 1);
    localparam logic signed [PW-1:0] HALF_P = PW'((66'd1 << SH_P) >> 1);
    localparam logic signed [SW-1:0] LIM_S  = SW'(64'd1 << OUT_FRAC_BITS);
    localparam logic signed [PW-1:0] LIM_P  = PW'(64'd1 << OUT_FRAC_BITS);

    typedef struct packed {
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
    } cs_t;

    typedef struct packed {
        logic [FW-1:0] forward_x;
        logic [FW-1:0] forward_y;
        logic [FW-1:0] forward_z;
        logic [FW-1:0] right_x;
        logic [FW-1:0] right_z;
        logic [FW-1:0] up_x;
        logic [FW-1:0] up_y;
        logic [FW-1:0] up_z;
        logic          clamped;
    } out_t;

    logic                    p_valid_reg;
    logic                    p_ready;
    cs_t                     yaw_cs, pitch_cs;
    logic signed [CW-1:0]    p_cy_reg, p_sy_reg, p_cp_reg, p_sp_reg;
    logic signed [2*CW-1:0]  p_cycp_reg, p_cycp_next;
    logic signed [2*CW-1:0]  p_sycp_reg, p_sycp_next;
    logic signed [2*CW-1:0]  p_cysp_reg, p_cysp_next;
    logic signed [2*CW-1:0]  p_sysp_reg, p_sysp_next;
    logic                    p_clamp_reg;

    logic                    o_valid_reg;
    logic                    o_ready;
    out_t                    o_data_reg, o_data_next;

    function automatic cs_t quad_map(input ecb_pkg::rot_t r, input logic [1:0] q);
        cs_t v;
        case (q)
            2'd0:    begin v.c = r.x;  v.s = r.y;  end
            2'd1:    begin v.c = -r.y; v.s = r.x;  end
            2'd2:    begin v.c = -r.x; v.s = -r.y; end
            default: begin v.c = r.y;  v.s = -r.x; end
        endcase
        return v;
    endfunction

    // round half up at the output fraction, then saturate to plus or minus one
    function automatic logic [FW-1:0] round_single(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + HALF_S) >>> SH_S;
        if (r > LIM_S)
        begin
            r = LIM_S;
        end
        else if (r < -LIM_S)
        begin
            r = -LIM_S;
        end
        return r[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] round_prod(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + HALF_P) >>> SH_P;
        if (r > LIM_P)
        begin
            r = LIM_P;
        end
        else if (r < -LIM_P)
        begin
            r = -LIM_P;
        end
        return r[FW-1:0];
    endfunction

    assign p_ready  = !p_valid_reg || o_ready;
    assign o_ready  = !o_valid_reg || basis.ready;
    assign ready_up = p_ready;

    always_comb
    begin
        yaw_cs      = quad_map(beat_up.yaw, beat_up.yaw_quad);
        pitch_cs    = quad_map(beat_up.pitch, beat_up.pitch_quad);
        p_cycp_next = yaw_cs.c * pitch_cs.c;
        p_sycp_next = yaw_cs.s * pitch_cs.c;
        p_cysp_next = yaw_cs.c * pitch_cs.s;
        p_sysp_next = yaw_cs.s * pitch_cs.s;
    end

    always_comb
    begin
        o_data_next.forward_x = round_prod(PW'(p_cycp_reg));
        o_data_next.forward_y = round_single(SW'(p_sp_reg));
        o_data_next.forward_z = round_prod(PW'(p_sycp_reg));
        o_data_next.right_x   = round_single(-SW'(p_sy_reg));
        o_data_next.right_z   = round_single(SW'(p_cy_reg));
        o_data_next.up_x      = round_prod(-PW'(p_cysp_reg));
        o_data_next.up_y      = round_single(SW'(p_cp_reg));
        o_data_next.up_z      = round_prod(-PW'(p_sysp_reg));
        o_data_next.clamped   = p_clamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
            begin
                p_valid_reg <= valid_up;
            end
            if (o_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && valid_up)
        begin
            p_cy_reg    <= yaw_cs.c;
            p_sy_reg    <= yaw_cs.s;
            p_cp_reg    <= pitch_cs.c;
            p_sp_reg    <= pitch_cs.s;
            p_cycp_reg  <= p_cycp_next;
            p_sycp_reg  <= p_sycp_next;
            p_cysp_reg  <= p_cysp_next;
            p_sysp_reg  <= p_sysp_next;
            p_clamp_reg <= beat_up.clamped;
        end
        if (o_ready && p_valid_reg)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign basis.valid             = o_valid_reg;
    assign basis.forward_x         = o_data_reg.forward_x;
    assign basis.forward_y         = o_data_reg.forward_y;
    assign basis.forward_z         = o_data_reg.forward_z;
    assign basis.right_x           = o_data_reg.right_x;
    assign basis.right_y           = '0;
    assign basis.right_z           = o_data_reg.right_z;
    assign basis.up_x              = o_data_reg.up_x;
    assign basis.up_y              = o_data_reg.up_y;
    assign basis.up_z              = o_data_reg.up_z;
    assign basis.pitch_was_clamped = o_data_reg.clamped;

    // pitch is held inside plus or minus 89 degrees, so its cosine stays positive
    p_cos_pitch_pos: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (p_cp_reg > 0))
        else $error("cos pitch not positive");

    o_up_y_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (basis.valid && (OUT_FRAC_BITS <= 14)) |-> !basis.up_y[FW-1])
        else $error("up_y negative");

endmodule

### design/euler_camera_basis.sv
// Top level of the Euler-angle camera basis: front end, CORDIC cell chain, back end.
// Depends on ecb_pkg, ecb_if, ecb_front, ecb_cordic_cell and ecb_back.
//
// Usage:
//   angles (sink):  one beat carries yaw_angle and pitch_angle, signed, 1/64 degree.
//   basis (source): one beat per input beat with forward, right and up vectors in
//                   Q2.14 (OUT_FRAC_BITS fraction bits) and pitch_was_clamped.
//   Yaw wraps into 0..360 degrees; pitch is limited to plus or minus 89 degrees.
//   A beat taken on angles passes through three front-end stages, one register per
//   CORDIC cell, a product stage and the output register before it shows on basis.
//   Throughput: one beat per cycle while basis.ready is high; every stage is a
//   register with its own valid bit.
//   Reset (rst_n low) empties the pipeline: all valid bits clear, data is kept.
//   When basis.ready is low the output holds; upstream stages keep filling their
//   empty slots, and angles.ready falls only once all CORDIC_STAGES + 5 stages hold
//   a beat. Results come out in the order the angles went in.

module euler_camera_basis
#(
    parameter int OUT_FRAC_BITS = ecb_pkg::OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = ecb_pkg::CORDIC_STAGES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ecb_in_if.sink     angles,
    ecb_out_if.source  basis
);

    logic [CORDIC_STAGES:0] chain_valid;
    logic [CORDIC_STAGES:0] chain_ready;
    ecb_pkg::cordic_beat_t  chain_beat [CORDIC_STAGES+1];

    ecb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .angles   (angles),
        .valid_dn (chain_valid[0]),
        .ready_dn (chain_ready[0]),
        .beat_dn  (chain_beat[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        ecb_cordic_cell
        #(
            .STAGE (i)
        )
        u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_up (chain_valid[i]),
            .ready_up (chain_ready[i]),
            .beat_up  (chain_beat[i]),
            .valid_dn (chain_valid[i+1]),
            .ready_dn (chain_ready[i+1]),
            .beat_dn  (chain_beat[i+1])
        );
    end

    ecb_back
    #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_up (chain_valid[CORDIC_STAGES]),
        .ready_up (chain_ready[CORDIC_STAGES]),
        .beat_up  (chain_beat[CORDIC_STAGES]),
        .basis    (basis)
    );

endmodule

### test/testbench.sv
// Self-checking bench for euler_camera_basis: angle pairs in, camera basis vectors out.
// Depends on ecb_pkg and the ecb_in_if / ecb_out_if channel interfaces from the design.
// Each result is checked against a bit-exact CORDIC predictor kept in this file.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 14;
    localparam int STAGES      = 16;
    localparam int FULL_TURN   = 23040;
    localparam int PITCH_MAX   = 5696;
    localparam int NUM_RANDOM  = 1150;
    localparam int CALM_TAIL   = 120;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 200000;
    localparam longint UNIT_GAIN = 64'sd652032874;

    localparam logic [31:0] ARC_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } angle_pair_t;

    typedef struct {
        logic [15:0] fwd_x;
        logic [15:0] fwd_y;
        logic [15:0] fwd_z;
        logic [15:0] rgt_x;
        logic [15:0] rgt_y;
        logic [15:0] rgt_z;
        logic [15:0] up_x;
        logic [15:0] up_y;
        logic [15:0] up_z;
        logic        clamped;
    } basis_t;

    logic clk;
    logic rst_n;

    ecb_in_if  angles_ch ();
    ecb_out_if basis_ch ();

    euler_camera_basis #(
        .OUT_FRAC_BITS (FRAC_BITS),
        .CORDIC_STAGES (STAGES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles_ch),
        .basis  (basis_ch)
    );

    angle_pair_t pending_pairs[$];
    basis_t      expected_basis[$];
    angle_pair_t next_pair;
    basis_t      seen_basis;
    basis_t      want_basis;
    int          error_count;
    int          result_count;
    int          cycle_count;
    int          send_gap;
    int          stall_left;
    logic        calm;

    // binary angle, 2^32 per turn, from 1/64 degree units
    function automatic logic [31:0] turn_angle(input int units);
        int m;
        longint unsigned t;
        m = units % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        t = (longint'(m) << 32) + longint'(FULL_TURN / 2);
        return 32'(t / longint'(FULL_TURN));
    endfunction

    function automatic void cordic_sincos(input logic [31:0] a, output longint c,
                                          output longint s);
        quadrant_t quad;
        logic [31:0] rem;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int i;
        quad = quadrant_t'(a[31:30]);
        rem  = {2'b00, a[29:0]};
        x = UNIT_GAIN;
        y = 0;
        // fold the remainder into -45 .. 45 degrees
        if (rem >= 32'h2000_0000)
        begin
            quad = quadrant_t'(quad + 2'd1);
            z = longint'(rem) - longint'(32'h4000_0000);
        end
        else
        begin
            z = longint'(rem);
        end
        for (i = 0; i < STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ARC_TURNS[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ARC_TURNS[i]);
            end
        end
        case (quad)
            QUAD_0:   begin c = x;  s = y;  end
            QUAD_90:  begin c = -y; s = x;  end
            QUAD_180: begin c = -x; s = -y; end
            default:  begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic logic [15:0] to_field(input longint v, input int frac_in);
        int sh;
        longint r;
        longint lim;
        sh  = frac_in - FRAC_BITS;
        lim = longint'(1) <<< FRAC_BITS;
        if (sh == 0)
            r = v;
        else
            r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

    function automatic basis_t predict_basis(input logic signed [15:0] yaw,
                                             input logic signed [15:0] pitch);
        int p;
        longint cy;
        longint sy;
        longint cp;
        longint sp;
        basis_t b;
        p = pitch;
        b.clamped = 1'b0;
        if (p > PITCH_MAX)
        begin
            p = PITCH_MAX;
            b.clamped = 1'b1;
        end
        else if (p < -PITCH_MAX)
        begin
            p = -PITCH_MAX;
            b.clamped = 1'b1;
        end
        cordic_sincos(turn_angle(int'(yaw)), cy, sy);
        cordic_sincos(turn_angle(p), cp, sp);
        b.fwd_x = to_field(cy * cp, 60);
        b.fwd_y = to_field(sp, 30);
        b.fwd_z = to_field(sy * cp, 60);
        b.rgt_x = to_field(-sy, 30);
        b.rgt_y = 16'd0;
        b.rgt_z = to_field(cy, 30);
        b.up_x  = to_field(-(cy * sp), 60);
        b.up_y  = to_field(cp, 30);
        b.up_z  = to_field(-(sy * sp), 60);
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, $signed(got),
                                      $signed(want)));
    endtask

    task automatic add_pair(input int yaw, input int pitch);
        angle_pair_t ap;
        ap.yaw   = 16'(yaw);
        ap.pitch = 16'(pitch);
        pending_pairs.push_back(ap);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // no idling near the end of the stimulus or in every fourth window of cycles
    assign calm = (pending_pairs.size() < CALM_TAIL) || (((cycle_count / 200) % 4) == 3);

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // angle driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angles_ch.valid       <= 1'b0;
            angles_ch.yaw_angle   <= '0;
            angles_ch.pitch_angle <= '0;
            send_gap = 0;
        end
        else
        begin
            if (angles_ch.valid && angles_ch.ready)
                expected_basis.push_back(predict_basis(angles_ch.yaw_angle,
                                                       angles_ch.pitch_angle));
            if (!angles_ch.valid || angles_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    angles_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 6) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    angles_ch.valid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    next_pair = pending_pairs.pop_front();
                    angles_ch.valid       <= 1'b1;
                    angles_ch.yaw_angle   <= next_pair.yaw;
                    angles_ch.pitch_angle <= next_pair.pitch;
                end
                else
                begin
                    angles_ch.valid <= 1'b0;
                end
            end
        end
    end

    // basis monitor and ready stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (basis_ch.valid && basis_ch.ready)
            begin
                if (expected_basis.size() == 0)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    want_basis = expected_basis.pop_front();
                    seen_basis.fwd_x   = basis_ch.forward_x;
                    seen_basis.fwd_y   = basis_ch.forward_y;
                    seen_basis.fwd_z   = basis_ch.forward_z;
                    seen_basis.rgt_x   = basis_ch.right_x;
                    seen_basis.rgt_y   = basis_ch.right_y;
                    seen_basis.rgt_z   = basis_ch.right_z;
                    seen_basis.up_x    = basis_ch.up_x;
                    seen_basis.up_y    = basis_ch.up_y;
                    seen_basis.up_z    = basis_ch.up_z;
                    seen_basis.clamped = basis_ch.pitch_was_clamped;
                    check_field("forward_x", seen_basis.fwd_x, want_basis.fwd_x);
                    check_field("forward_y", seen_basis.fwd_y, want_basis.fwd_y);
                    check_field("forward_z", seen_basis.fwd_z, want_basis.fwd_z);
                    check_field("right_x", seen_basis.rgt_x, want_basis.rgt_x);
                    check_field("right_y", seen_basis.rgt_y, want_basis.rgt_y);
                    check_field("right_z", seen_basis.rgt_z, want_basis.rgt_z);
                    check_field("up_x", seen_basis.up_x, want_basis.up_x);
                    check_field("up_y", seen_basis.up_y, want_basis.up_y);
                    check_field("up_z", seen_basis.up_z, want_basis.up_z);
                    check_field("pitch_was_clamped", {15'd0, seen_basis.clamped},
                                {15'd0, want_basis.clamped});
                end
                result_count++;
            end
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                basis_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                basis_ch.ready <= 1'b0;
            end
            else
            begin
                basis_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int i;
        int kind;
        int sign;
        rst_n = 1'b0;

        // directed: field extremes, wrap points, clamp edges, octant boundaries
        add_pair(0, 0);
        add_pair(32767, 32767);
        add_pair(-32768, -32768);
        add_pair(32767, -32768);
        add_pair(-32768, 32767);
        add_pair(23040, PITCH_MAX);
        add_pair(-23040, -PITCH_MAX);
        add_pair(0, PITCH_MAX + 1);
        add_pair(0, -PITCH_MAX - 1);
        add_pair(23039, PITCH_MAX - 1);
        add_pair(-1, 1);
        add_pair(1, -1);
        add_pair(2880, 0);
        add_pair(5760, -2880);
        add_pair(8640, 0);
        add_pair(11520, 2880);
        add_pair(14400, -1000);
        add_pair(17280, 0);
        add_pair(20160, 1440);
        add_pair(-5760, 4000);
        add_pair(2879, 2881);
        add_pair(-2880, -2880);
        add_pair(46080, 5760);

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            kind = $urandom_range(0, 99);
            sign = $urandom_range(0, 1) ? 1 : -1;
            if (kind < 30)
                add_pair($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            else if (kind < 70)
                add_pair($urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 2 * PITCH_MAX) - PITCH_MAX);
            else if (kind < 85)
                add_pair($urandom_range(0, 65535) - 32768,
                         sign * (PITCH_MAX - 6 + $urandom_range(0, 12)));
            else
                add_pair(($urandom_range(0, 22) - 11) * 2880 + $urandom_range(0, 6) - 3,
                         $urandom_range(0, 11600) - 5800);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_pairs.size() != 0 || angles_ch.valid || expected_basis.size() != 0);
        repeat (DRAIN) @(posedge clk);

        if (expected_basis.size() != 0)
            report_mismatch("expected results left over");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
